// ===== sv/scl_pkg.sv =====
// Shared types and constants of the serial command line parser.
package scl_pkg;

  localparam int NAME_W  = 64;
  localparam int VAL_W   = 18;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd2;

  // Summary of a finished line, handed from the parser to the emitter.
  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [COUNT_W-1:0] count;
    logic               too_many;
  } line_info_t;

endpackage

// ===== sv/scl_parser.sv =====
// Per-byte line parser: name packing, separator counting and number conversion.
module scl_parser #(
  parameter int MAX_PARAMS = 8,
  parameter int NAME_CHARS = 8,
  parameter int LINE_BYTES = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  input  logic [7:0]              end_char,
  input  logic [7:0]              open_char,
  input  logic [7:0]              delim_char,
  input  logic                    em_busy,
  output logic                    take,
  output logic                    load,
  output scl_pkg::line_info_t     info,
  output logic [scl_pkg::VAL_W-1:0] vals [MAX_PARAMS]
);
  import scl_pkg::*;

  localparam int NLW = $clog2(NAME_CHARS + 1);
  localparam int DCW = $clog2(MAX_PARAMS + 2);
  localparam int KW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int LBW = $clog2(LINE_BYTES);
  localparam int ACC_W = VAL_W - 1;

  localparam logic [2:0] MODE_LEAD   = 3'd0;
  localparam logic [2:0] MODE_SIGNED = 3'd1;
  localparam logic [2:0] MODE_ZERO   = 3'd2;
  localparam logic [2:0] MODE_HEX    = 3'd3;
  localparam logic [2:0] MODE_OCT    = 3'd4;
  localparam logic [2:0] MODE_DEC    = 3'd5;
  localparam logic [2:0] MODE_DONE   = 3'd6;

  localparam logic [2:0]     FIELD_MAX = 3'd5;
  localparam logic [DCW-1:0] DC_MAX    = DCW'(MAX_PARAMS);
  localparam logic [LBW-1:0] LB_LAST   = LBW'(LINE_BYTES - 1);

  logic [NAME_CHARS*8-1:0] name_reg, name_reg_next;
  logic [NLW-1:0]   name_len, name_len_next;
  logic             in_params, in_params_next;
  logic [DCW-1:0]   delim_count, delim_count_next;
  logic             prev_was_delim, prev_was_delim_next;
  logic [2:0]       field_chars, field_chars_next;
  logic [ACC_W-1:0] accum, accum_next;
  logic [2:0]       num_mode, num_mode_next;
  logic             num_neg, num_neg_next;
  logic [LBW-1:0]   line_bytes, line_bytes_next;
  logic [VAL_W-1:0] param_store [MAX_PARAMS];

  logic             is_ovf, is_end, is_sep, is_ws;
  logic             finish_ok, store_we;
  logic [DCW-1:0]   dc_minus;
  logic [KW-1:0]    wr_idx;
  logic [VAL_W-1:0] fin_val;
  logic [4:0]       hex_d;
  logic             hex_ok, dec_ok, oct_ok;
  logic [COUNT_W-1:0] count;

  assign is_ovf = (line_bytes == LB_LAST);
  assign is_end = (in_byte == end_char);
  assign is_sep = (in_byte == open_char) || (in_byte == delim_char);
  assign is_ws  = (in_byte == 8'd32) || (in_byte >= 8'd9 && in_byte <= 8'd13);

  // An end byte may only pass once the emitter has room for its results.
  assign take = in_valid && (is_ovf || !is_end || !em_busy);
  assign load = in_valid && !is_ovf && is_end && !em_busy;

  always_comb begin
    hex_d  = 5'd0;
    hex_ok = 1'b1;
    if (in_byte >= "0" && in_byte <= "9") begin
      hex_d = 5'(in_byte - "0");
    end else if (in_byte >= "a" && in_byte <= "f") begin
      hex_d = 5'(in_byte - "a" + 8'd10);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      hex_d = 5'(in_byte - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign dec_ok = (in_byte >= "0") && (in_byte <= "9");
  assign oct_ok = (in_byte >= "0") && (in_byte <= "7");

  assign dc_minus  = delim_count - DCW'(1);
  assign wr_idx    = dc_minus[KW-1:0];
  assign finish_ok = in_params && (delim_count != '0) && (delim_count <= DC_MAX);
  assign fin_val   = num_neg ? (VAL_W'(0) - {1'b0, accum}) : {1'b0, accum};
  assign store_we  = take && !is_ovf && (is_end || is_sep) && finish_ok;

  always_comb begin
    if (!in_params || prev_was_delim) begin
      count = '0;
    end else if (delim_count > DC_MAX) begin
      count = COUNT_W'(MAX_PARAMS);
    end else begin
      count = COUNT_W'(delim_count);
    end
  end

  assign info.name     = NAME_W'(name_reg);
  assign info.count    = count;
  assign info.too_many = (delim_count > DC_MAX);

  // The field still open at the end byte is merged in as it is stored.
  always_comb begin
    for (int j = 0; j < MAX_PARAMS; j++) begin
      vals[j] = (finish_ok && wr_idx == KW'(j)) ? fin_val : param_store[j];
    end
  end

  always_comb begin
    name_reg_next       = name_reg;
    name_len_next       = name_len;
    in_params_next      = in_params;
    delim_count_next    = delim_count;
    prev_was_delim_next = prev_was_delim;
    field_chars_next    = field_chars;
    accum_next          = accum;
    num_mode_next       = num_mode;
    num_neg_next        = num_neg;
    line_bytes_next     = line_bytes + LBW'(1);

    if (is_ovf || is_end) begin
      name_reg_next       = '0;
      name_len_next       = '0;
      in_params_next      = 1'b0;
      delim_count_next    = '0;
      prev_was_delim_next = 1'b0;
      line_bytes_next     = '0;
      field_chars_next    = '0;
      accum_next          = '0;
      num_mode_next       = MODE_LEAD;
      num_neg_next        = 1'b0;
    end else if (is_sep) begin
      in_params_next      = 1'b1;
      prev_was_delim_next = 1'b1;
      if (delim_count <= DC_MAX) begin
        delim_count_next = delim_count + DCW'(1);
      end
      field_chars_next = '0;
      accum_next       = '0;
      num_mode_next    = MODE_LEAD;
      num_neg_next     = 1'b0;
    end else begin
      prev_was_delim_next = 1'b0;
      if (!in_params) begin
        if (name_len < NLW'(NAME_CHARS)) begin
          for (int i = 0; i < NAME_CHARS; i++) begin
            if (name_len == NLW'(i)) begin
              name_reg_next[8*i +: 8] = in_byte;
            end
          end
          name_len_next = name_len + NLW'(1);
        end
      end else if (field_chars < FIELD_MAX && num_mode != MODE_DONE) begin
        field_chars_next = field_chars + 3'd1;
        unique case (num_mode)
          MODE_LEAD, MODE_SIGNED: begin
            if (num_mode == MODE_LEAD && is_ws) begin
              num_mode_next = MODE_LEAD;
            end else if (num_mode == MODE_LEAD && in_byte == "+") begin
              num_mode_next = MODE_SIGNED;
            end else if (num_mode == MODE_LEAD && in_byte == "-") begin
              num_neg_next  = 1'b1;
              num_mode_next = MODE_SIGNED;
            end else if (in_byte == "0") begin
              num_mode_next = MODE_ZERO;
            end else if (dec_ok) begin
              accum_next    = ACC_W'(hex_d);
              num_mode_next = MODE_DEC;
            end else begin
              num_mode_next = MODE_DONE;
            end
          end
          MODE_ZERO: begin
            if (in_byte == "x" || in_byte == "X") begin
              num_mode_next = MODE_HEX;
            end else if (oct_ok) begin
              accum_next    = ACC_W'(hex_d);
              num_mode_next = MODE_OCT;
            end else begin
              num_mode_next = MODE_DONE;
            end
          end
          MODE_HEX: begin
            if (hex_ok) accum_next = ACC_W'({accum, 4'd0} + ACC_W'(hex_d));
            else        num_mode_next = MODE_DONE;
          end
          MODE_OCT: begin
            if (oct_ok) accum_next = ACC_W'({accum, 3'd0} + ACC_W'(hex_d));
            else        num_mode_next = MODE_DONE;
          end
          MODE_DEC: begin
            if (dec_ok) accum_next = ACC_W'(accum * ACC_W'(10) + ACC_W'(hex_d));
            else        num_mode_next = MODE_DONE;
          end
          default: begin
            num_mode_next = MODE_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_reg       <= '0;
      name_len       <= '0;
      in_params      <= 1'b0;
      delim_count    <= '0;
      prev_was_delim <= 1'b0;
      field_chars    <= '0;
      accum          <= '0;
      num_mode       <= MODE_LEAD;
      num_neg        <= 1'b0;
      line_bytes     <= '0;
    end else if (take) begin
      name_reg       <= name_reg_next;
      name_len       <= name_len_next;
      in_params      <= in_params_next;
      delim_count    <= delim_count_next;
      prev_was_delim <= prev_was_delim_next;
      field_chars    <= field_chars_next;
      accum          <= accum_next;
      num_mode       <= num_mode_next;
      num_neg        <= num_neg_next;
      line_bytes     <= line_bytes_next;
    end
  end

  // Every entry below the reported count is written before it is read,
  // so the store needs no clearing.
  always_ff @(posedge clk) begin
    if (store_we) begin
      param_store[wr_idx] <= fin_val;
    end
  end

endmodule

// ===== sv/scl_emitter.sv =====
// Result buffer: holds one finished line and hands out its results one per cycle while out_ready is high.
module scl_emitter #(
  parameter int MAX_PARAMS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  scl_pkg::line_info_t        info,
  input  logic [scl_pkg::VAL_W-1:0]  vals [MAX_PARAMS],
  output logic                       busy,
  output logic                       full,
  input  logic                       out_ready,
  output logic [scl_pkg::NAME_W-1:0] cmd_name,
  output logic [3:0]                 param_count,
  output logic [2:0]                 param_index,
  output logic [scl_pkg::VAL_W-1:0]  param_value,
  output logic                       too_many,
  output logic                       last
);
  import scl_pkg::*;

  localparam int KW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  line_info_t       held;
  logic [VAL_W-1:0] held_vals [MAX_PARAMS];
  logic [KW-1:0]    k;
  logic [COUNT_W-1:0] k_ext;

  assign k_ext       = COUNT_W'(k);
  assign last        = (held.count == '0) || (k_ext + COUNT_W'(1) == held.count);
  assign cmd_name    = held.name;
  assign param_count = held.count[3:0];
  assign param_index = k_ext[2:0];
  assign param_value = (held.count == '0) ? '0 : held_vals[k];
  assign too_many    = held.too_many;

  // The buffer frees up in the cycle its final result is accepted, so the next
  // line can be loaded at that same edge.
  assign full = busy && !(out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (load) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held      <= info;
      held_vals <= vals;
    end
  end

endmodule

// ===== sv/serial_command_line_parser.sv =====
// Serial command line parser: top level with input register and configuration registers.
// The block takes one received byte per cycle while no end byte is held back, and parses
// lines of the form name, open byte, delimited integer parameters, end byte; each
// parameter is read as C %i reads it, from at most five characters. On the end byte it
// emits one result per parameter, or one result when there are none, the final one with
// tlast set; results leave at one per cycle while m_tready is high. The end byte passes
// through the input register and the line is then loaded into the emitter's buffer, which
// offers its first result. Bytes of the next line keep flowing in while results are still
// being sent, but that line's end byte waits in the input register until the final result
// of the previous line is being accepted, so a line with n parameters sends max(n,1)
// results, with no idle cycle between the results of consecutive lines. Configuration is
// accepted in every cycle and should only change while no line is in progress.
module serial_command_line_parser #(
  parameter int MAX_PARAMS = 8,
  parameter int NAME_CHARS = 8,
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // cmd_name, param_count, param_index, param_value, too_many
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [scl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);
  import scl_pkg::*;

  logic [7:0] end_char, open_char, delim_char;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       take, load, em_busy, em_full;
  line_info_t info;
  logic [VAL_W-1:0] vals [MAX_PARAMS];

  logic [NAME_W-1:0] cmd_name;
  logic [3:0]        param_count;
  logic [2:0]        param_index;
  logic [VAL_W-1:0]  param_value;
  logic              too_many;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char   <= 8'd10;
      open_char  <= 8'd40;
      delim_char <= 8'd44;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_END:   end_char   <= cfg_data;
        CFG_OPEN:  open_char  <= cfg_data;
        CFG_DELIM: delim_char <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  scl_parser #(
    .MAX_PARAMS (MAX_PARAMS),
    .NAME_CHARS (NAME_CHARS),
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .end_char   (end_char),
    .open_char  (open_char),
    .delim_char (delim_char),
    .em_busy    (em_full),
    .take       (take),
    .load       (load),
    .info       (info),
    .vals       (vals)
  );

  scl_emitter #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .info        (info),
    .vals        (vals),
    .busy        (em_busy),
    .full        (em_full),
    .out_ready   (m_tready),
    .cmd_name    (cmd_name),
    .param_count (param_count),
    .param_index (param_index),
    .param_value (param_value),
    .too_many    (too_many),
    .last        (m_tlast)
  );

  assign m_tvalid = em_busy;
  assign m_tdata  = {6'd0, too_many, param_value, param_index, param_count, cmd_name};

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(load && em_full))
    else $error("line loaded while results still pending");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
    else $error("results continue after the final one of a line");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !take) |=> (in_valid && $stable(in_byte)))
    else $error("held input byte lost or changed");

endmodule
